// File: sv/rth_pkg.sv
// Package for the RGB to HSV pixel converter.
// Holds the hue sector type, the divider stage record and the shared
// divide step. No dependencies.
package rth_pkg;

  // Number of divider stages; each retires two hue quotient bits and one
  // saturation quotient bit.
  localparam int unsigned DIV_STAGES = 8;

  // A full turn of hue in units of 1/64 degree.
  localparam logic [14:0] HUE_FULL = 15'd23040;

  // Which component is the largest, with red winning ties, then green.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Payload carried through the divider stages.
  typedef struct packed {
    logic [7:0]  mx;     // largest component, also the saturation divisor
    logic [7:0]  delta;  // largest minus smallest, also the hue divisor
    logic        neg;    // hue numerator is negative
    logic        gray;   // all components equal
    logic [7:0]  hrem;   // hue partial remainder
    logic [15:0] hnum;   // hue dividend bits not yet shifted in
    logic [15:0] hquo;   // hue quotient bits so far
    logic [7:0]  srem;   // saturation partial remainder
    logic [7:0]  snum;   // saturation dividend bits not yet shifted in
    logic [7:0]  squo;   // saturation quotient bits so far
  } dstage_t;

  // One restoring division step. The remainder stays below the divisor,
  // so it fits in eight bits. Returns the quotient bit above the new
  // remainder.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                          input logic [7:0] dsr);
    logic [8:0] t;
    logic [8:0] res;
    t = {rem, nb};
    if (t >= {1'b0, dsr}) begin
      res = {1'b1, 8'(t - {1'b0, dsr})};
    end else begin
      res = {1'b0, t[7:0]};
    end
    return res;
  endfunction

endpackage

// File: sv/rth_if.sv
// Valid/ready channel interfaces for the RGB to HSV pixel converter.
// rth_rgb_if carries one input pixel, rth_hsv_if one converted pixel.
// No dependencies.
interface rth_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic        gray;

  modport source (output valid, output hue, output saturation, output brightness,
                  output gray, input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                input gray, output ready);
endinterface

// File: sv/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter: a fully pipelined datapath.
// Depends on rth_pkg and the channel interfaces in rth_if.sv.
//
// Usage: pixels arrive on the rgb channel (valid/ready, 8-bit red, green,
// blue) and leave on the hsv channel (valid/ready, 15-bit hue in 1/64
// degree, 8-bit saturation, 8-bit brightness and a gray flag). An item is
// taken at a rising edge where valid and ready are both high.
// Throughput is one item per clock while the receiver takes results. There
// are eleven register stages, and the first of them loads at the accepting
// edge itself: one stage finds the largest and smallest component, one forms
// the hue numerator and both dividends, eight divider stages each retire two
// hue and one saturation quotient bits, and one stage corrects the hue sign
// and registers the result.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up and a stalled receiver only
// backs up the stages that hold items; rgb.ready drops once all are full.
// A result held on the hsv channel stays stable until taken.
// Reset (synchronous, active high) empties every stage; no result is shown
// in the cycle after reset and rgb.ready is high.
module rgb_to_hsv_pixel (
  input logic        clk,
  input logic        rst,
  rth_rgb_if.sink    rgb,
  rth_hsv_if.source  hsv
);
  import rth_pkg::*;

  // Stage A: extremes, sector and signed component difference.
  logic              a_v;
  logic [7:0]        a_mx;
  logic [7:0]        a_delta;
  sector_t           a_sec;
  logic signed [8:0] a_diff;

  // Stage B (index 0) and the divider stages (1 to DIV_STAGES).
  logic [DIV_STAGES:0] vs;
  dstage_t             st      [DIV_STAGES+1];
  dstage_t             st_next [DIV_STAGES+1];

  // Output register.
  logic        vo;
  logic [14:0] o_hue;
  logic [7:0]  o_sat;
  logic [7:0]  o_bri;
  logic        o_gray;

  // Per-stage load enables.
  logic                rdy_a;
  logic [DIV_STAGES:0] rdy_s;
  logic                rdy_o;

  // Stage A combinational values.
  logic [7:0]        mx_c;
  logic [7:0]        mn_c;
  sector_t           sec_c;
  logic signed [8:0] diff_c;

  // Stage B combinational values.
  logic [10:0]        bd_c;
  logic signed [11:0] n_c;
  logic [10:0]        mag_c;
  logic [23:0]        hd_c;
  logic [15:0]        sd_c;
  dstage_t            b_next;

  // Output stage combinational values.
  logic [14:0] q_c;
  logic [14:0] hue_c;
  logic [7:0]  sat_c;

  // A stage may load when it is empty or its contents move on this edge.
  always_comb begin
    rdy_o             = !vo || hsv.ready;
    rdy_s[DIV_STAGES] = !vs[DIV_STAGES] || rdy_o;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy_s[k] = !vs[k] || rdy_s[k+1];
    end
    rdy_a = !a_v || rdy_s[0];
  end

  assign rgb.ready = rdy_a;

  // Largest, smallest, and which component leads. Ties go to red, then green.
  always_comb begin
    mx_c = (rgb.red > rgb.green) ? rgb.red : rgb.green;
    mx_c = (mx_c > rgb.blue) ? mx_c : rgb.blue;
    mn_c = (rgb.red < rgb.green) ? rgb.red : rgb.green;
    mn_c = (mn_c < rgb.blue) ? mn_c : rgb.blue;
    if (rgb.red >= mx_c) begin
      sec_c  = SEC_RED;
      diff_c = $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
    end else if (rgb.green >= mx_c) begin
      sec_c  = SEC_GREEN;
      diff_c = $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
    end else begin
      sec_c  = SEC_BLUE;
      diff_c = $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
    end
  end

  // Hue numerator is (base * delta + diff) * 3840; its magnitude goes into
  // the divider and the sign rides alongside, which gives truncation toward
  // zero. 3840 is 4096 - 256, and 255 is 256 - 1.
  always_comb begin
    unique case (a_sec)
      SEC_RED:   bd_c = '0;
      SEC_GREEN: bd_c = {2'b00, a_delta, 1'b0};
      SEC_BLUE:  bd_c = {1'b0, a_delta, 2'b00};
      default:   bd_c = '0;
    endcase
    n_c   = $signed({1'b0, bd_c}) + 12'(a_diff);
    mag_c = n_c[11] ? 11'(-n_c) : n_c[10:0];
    hd_c  = {1'b0, mag_c, 12'b0} - {5'b0, mag_c, 8'b0};
    sd_c  = {a_delta, 8'b0} - {8'b0, a_delta};

    b_next.mx    = a_mx;
    b_next.delta = a_delta;
    b_next.neg   = n_c[11];
    b_next.gray  = (a_delta == 8'd0);
    b_next.hrem  = hd_c[23:16];
    b_next.hnum  = hd_c[15:0];
    b_next.hquo  = '0;
    b_next.srem  = sd_c[15:8];
    b_next.snum  = sd_c[7:0];
    b_next.squo  = '0;
  end

  // Divider stages. The quotients fit their widths because the dividends
  // stay below divisor times two to the quotient width. A gray pixel
  // divides by zero here; its quotients are discarded at the output.
  always_comb begin
    dstage_t    s;
    logic [8:0] step;
    st_next[0] = b_next;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      s = st[k-1];
      for (int b = 0; b < 2; b++) begin
        step   = div_step(s.hrem, s.hnum[15], s.delta);
        s.hrem = step[7:0];
        s.hquo = {s.hquo[14:0], step[8]};
        s.hnum = {s.hnum[14:0], 1'b0};
      end
      step       = div_step(s.srem, s.snum[7], s.mx);
      s.srem     = step[7:0];
      s.squo     = {s.squo[6:0], step[8]};
      s.snum     = {s.snum[6:0], 1'b0};
      st_next[k] = s;
    end
  end

  // A negative hue only happens in the red sector and is folded into
  // range by adding a full turn; a quotient of zero stays zero.
  always_comb begin
    q_c = st[DIV_STAGES].hquo[14:0];
    if (st[DIV_STAGES].gray) begin
      hue_c = '0;
      sat_c = '0;
    end else begin
      hue_c = (st[DIV_STAGES].neg && (q_c != 15'd0)) ? (HUE_FULL - q_c) : q_c;
      sat_c = st[DIV_STAGES].squo;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      vs  <= '0;
      vo  <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_v <= rgb.valid;
      end
      if (rdy_s[0]) begin
        vs[0] <= a_v;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (rdy_s[k]) begin
          vs[k] <= vs[k-1];
        end
      end
      if (rdy_o) begin
        vo <= vs[DIV_STAGES];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy_a && rgb.valid) begin
      a_mx    <= mx_c;
      a_delta <= mx_c - mn_c;
      a_sec   <= sec_c;
      a_diff  <= diff_c;
    end
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (rdy_s[k]) begin
        st[k] <= st_next[k];
      end
    end
    if (rdy_o) begin
      o_hue  <= hue_c;
      o_sat  <= sat_c;
      o_bri  <= st[DIV_STAGES].mx;
      o_gray <= st[DIV_STAGES].gray;
    end
  end

  assign hsv.valid      = vo;
  assign hsv.hue        = o_hue;
  assign hsv.saturation = o_sat;
  assign hsv.brightness = o_bri;
  assign hsv.gray       = o_gray;

endmodule

// File: sv/rth_check.sv
// Port-level checker for the RGB to HSV pixel converter, and the bind
// that attaches it to rgb_to_hsv_pixel. Depends on the top level.
module rth_check (
  input logic        clk,
  input logic        rst,
  input logic        hsv_valid,
  input logic        hsv_ready,
  input logic [14:0] hue,
  input logic [7:0]  saturation,
  input logic [7:0]  brightness,
  input logic        gray
);

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue) && $stable(saturation)
      && $stable(brightness) && $stable(gray))
    else $error("hsv result changed while stalled");

  // A gray pixel has no hue and no saturation.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && gray |-> hue == 15'd0 && saturation == 8'd0)
    else $error("gray result with nonzero hue or saturation");

  // A colored pixel has a nonzero largest component and a hue below a turn.
  a_color: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !gray |-> brightness != 8'd0 && hue < 15'd23040)
    else $error("colored result out of range");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !hsv_valid)
    else $error("result shown right after reset");

endmodule

bind rgb_to_hsv_pixel rth_check u_rth_check (
  .clk        (clk),
  .rst        (rst),
  .hsv_valid  (hsv.valid),
  .hsv_ready  (hsv.ready),
  .hue        (hsv.hue),
  .saturation (hsv.saturation),
  .brightness (hsv.brightness),
  .gray       (hsv.gray)
);
